@@ hdl/block_bitmap_allocator_macros.svh @@
// Assertion macros for the block bitmap allocator.
// Included by files that carry concurrent assertions; needs nothing else.
`ifndef BLOCK_BITMAP_ALLOCATOR_MACROS_SVH
`define BLOCK_BITMAP_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent holds, so the consequent must hold in the same cycle.
`define BBA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("block_bitmap_allocator: same-cycle check failed");

// Antecedent holds, so the consequent must hold in the next cycle.
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("block_bitmap_allocator: next-cycle check failed");

`else

`define BBA_ASSERT_IMP(label, clk, rst, ante, cons)
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hdl/bba_pkg.sv @@
// Shared types and constants for the block bitmap allocator.
// Used by every module of the block but the map memory; depends on nothing.
package bba_pkg;

  localparam int FUNC_W         = 2;
  localparam int INDEX_W        = 10;
  localparam int COUNT_W        = 11;
  localparam int WORD_W         = 32;
  localparam int WORD_SHIFT     = 5;
  localparam int DEF_MAX_BLOCKS = 1024;

  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;

  localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic issue;
  } scan_ctrl_t;

  typedef struct packed {
    logic busy;
    logic found;
  } scan_stat_t;

endpackage

@@ hdl/bba_map_mem.sv @@
// Usage map storage: one bit per block, packed into words.
// Simple dual-port synchronous memory with registered read data; no package use.
module bba_map_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int W     = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/bba_scan.sv @@
// Scan unit: takes map words in address order and accumulates the free count
// and the lowest free block. Depends on bba_pkg.
module bba_scan #(
  parameter int AW      = 5,
  parameter int CNT_W   = 11,
  parameter int FIRST_W = 10,
  parameter int TOT_W   = 11
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  bba_pkg::scan_ctrl_t                   ctl,
  input  logic [AW-1:0]                         word_addr,
  input  logic [CNT_W-1:0]                      count,
  input  logic [bba_pkg::WORD_W-1:0]            rdata,
  output bba_pkg::scan_stat_t                   stat,
  output logic [FIRST_W-1:0]                    first,
  output logic [TOT_W-1:0]                      total
);
  import bba_pkg::*;

  localparam int RW     = (CNT_W > AW + WORD_SHIFT) ? CNT_W : AW + WORD_SHIFT;
  localparam int PC_W   = WORD_SHIFT + 1;

  logic                  v1;
  logic [AW-1:0]         w1;
  logic                  v2;
  logic [AW-1:0]         w2;
  logic [PC_W-1:0]       pc2;
  logic                  any2;
  logic [WORD_SHIFT-1:0] fb2;
  logic                  found;

  logic [RW-1:0]         rem;
  logic [WORD_W-1:0]     mask;
  logic [WORD_W-1:0]     free_bits;
  logic [WORD_SHIFT-1:0] fb;

  // Stage one: tag that lines up with the memory's registered read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= ctl.issue;
    end
  end

  always_ff @(posedge clk) begin
    w1 <= word_addr;
  end

  // Bits at or beyond the block count are not part of the map in use.
  always_comb begin
    rem = RW'(count) - RW'({w1, {WORD_SHIFT{1'b0}}});
    if (rem >= RW'(WORD_W)) begin
      mask = '1;
    end else begin
      mask = (WORD_W'(1) << rem[WORD_SHIFT-1:0]) - WORD_W'(1);
    end
    free_bits = ~rdata & mask;
  end

  always_comb begin
    fb = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        fb = WORD_SHIFT'(b);
      end
    end
  end

  // Stage two: per-word free count and lowest free bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    w2   <= w1;
    pc2  <= PC_W'($countones(free_bits));
    any2 <= |free_bits;
    fb2  <= fb;
  end

  // Stage three: words arrive in ascending order, so the first word with a
  // free bit holds the lowest free block.
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      first <= '0;
      total <= '0;
    end else if (ctl.start) begin
      found <= 1'b0;
      first <= '0;
      total <= '0;
    end else if (v2) begin
      total <= total + TOT_W'(pc2);
      if (any2 && !found) begin
        found <= 1'b1;
        first <= FIRST_W'({w2, fb2});
      end
    end
  end

  assign stat.busy  = v1 | v2;
  assign stat.found = found;

endmodule

@@ hdl/bba_ctrl.sv @@
// Sequencer: configuration register, item capture, map clear pass,
// read-modify-write of one map word, scan control and the result register.
// Depends on bba_pkg.
module bba_ctrl #(
  parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS,
  parameter int AW         = 5,
  parameter int CNT_W      = 11,
  parameter int FIRST_W    = 10,
  parameter int TOT_W      = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bba_pkg::COUNT_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bba_pkg::FUNC_W-1:0]    func,
  input  logic [bba_pkg::INDEX_W-1:0]   block_index,
  input  logic [bba_pkg::COUNT_W-1:0]   needed_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          free_found,
  output logic [bba_pkg::INDEX_W-1:0]   first_free,
  output logic [bba_pkg::COUNT_W-1:0]   free_total,
  output logic                          enough_free,
  output logic                          index_error,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [bba_pkg::WORD_W-1:0]    mem_wdata,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [bba_pkg::WORD_W-1:0]    mem_rdata,
  output bba_pkg::scan_ctrl_t           scan_ctl,
  output logic [CNT_W-1:0]              scan_count,
  input  bba_pkg::scan_stat_t           scan_stat,
  input  logic [FIRST_W-1:0]            scan_first,
  input  logic [TOT_W-1:0]              scan_total
);
  import bba_pkg::*;

  localparam int NWORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int XW     = (COUNT_W > CNT_W) ? COUNT_W : CNT_W;
  localparam int IW     = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;
  localparam int IX     = (INDEX_W > AW + WORD_SHIFT) ? INDEX_W : AW + WORD_SHIFT;
  localparam int SW     = (CNT_W + 1 > AW + WORD_SHIFT + 1) ? CNT_W + 1 : AW + WORD_SHIFT + 1;

  state_t               state;
  state_t               state_next;
  logic [AW-1:0]        clr_addr;
  logic [COUNT_W-1:0]   block_count;
  logic [FUNC_W-1:0]    func_q;
  logic [INDEX_W-1:0]   idx_q;
  logic [COUNT_W-1:0]   need_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [AW:0]          nw_q;
  logic                 err_q;
  logic [AW:0]          scan_cnt;

  logic [XW-1:0]        bc_x;
  logic [CNT_W-1:0]     eff_count;
  logic [SW-1:0]        nw_sum;
  logic                 is_update;
  logic                 in_range;
  logic                 accept;
  logic                 issue;
  logic                 load_out;
  logic [IX-1:0]        idx_x;
  logic [AW-1:0]        upd_addr;
  logic [WORD_W-1:0]    bit_mask;

  // Counts above the map size saturate to the map size.
  always_comb begin
    bc_x      = XW'(block_count);
    eff_count = (bc_x > XW'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(bc_x);
    nw_sum    = SW'(eff_count) + SW'(WORD_W - 1);
    is_update = (func == FUNC_MARK) || (func == FUNC_FREE);
    in_range  = IW'(block_index) < IW'(eff_count);
    idx_x     = IX'(idx_q);
    upd_addr  = idx_x[AW+WORD_SHIFT-1:WORD_SHIFT];
    bit_mask  = WORD_W'(1) << idx_q[WORD_SHIFT-1:0];
    issue     = (state == ST_SCAN) && (scan_cnt < nw_q);
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= BLOCK_COUNT_RST;
    end else if (cfg_we) begin
      block_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(NWORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (is_update && in_range) ? ST_READ : ST_SCAN;
        end
      end
      ST_READ:  state_next = ST_WRITE;
      ST_WRITE: state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_cnt >= nw_q) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!scan_stat.busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready          = 1'b0;
    mem_we            = 1'b0;
    mem_waddr         = upd_addr;
    mem_wdata         = (func_q == FUNC_MARK) ? (mem_rdata | bit_mask)
                                              : (mem_rdata & ~bit_mask);
    mem_re            = 1'b0;
    mem_raddr         = scan_cnt[AW-1:0];
    scan_ctl.start    = accept;
    scan_ctl.issue    = 1'b0;
    load_out          = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_IDLE:  in_ready = 1'b1;
      ST_READ: begin
        mem_re    = 1'b1;
        mem_raddr = upd_addr;
      end
      ST_WRITE: mem_we = 1'b1;
      ST_SCAN: begin
        mem_re         = issue;
        scan_ctl.issue = issue;
      end
      ST_DRAIN: begin
      end
      ST_FINISH: load_out = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
    end else if (accept) begin
      scan_cnt <= '0;
    end else if (issue) begin
      scan_cnt <= scan_cnt + (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= func;
      idx_q  <= block_index;
      need_q <= needed_count;
      cnt_q  <= eff_count;
      nw_q   <= nw_sum[AW+WORD_SHIFT:WORD_SHIFT];
      err_q  <= is_update && !in_range;
    end
  end

  assign scan_count = cnt_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      free_found  <= scan_stat.found;
      first_free  <= scan_first[INDEX_W-1:0];
      free_total  <= scan_total[COUNT_W-1:0];
      enough_free <= (need_q != '0) && (TOT_W'(need_q) <= scan_total);
      index_error <= err_q;
    end
  end

endmodule

@@ hdl/block_bitmap_allocator.sv @@
// Channel   Handshake              Word contents
// cfg       cfg_we                 cfg_wdata = block_count
// in        in_valid / in_ready    func, block_index, needed_count
// out       out_valid / out_ready  free_found, first_free, free_total,
//                                  enough_free, index_error
//
// An item that updates the map first has its map word read and written back; then
// ceil(count / 32) map words are scanned, one word per cycle as the read port of the
// map memory allows, and the result is registered (count saturated to MAX_BLOCKS).
// After reset a clearing pass writes ceil(MAX_BLOCKS / 32) words with in_ready low;
// configuration writes are taken as ever. One item is in work at a time; a finished
// result waits in the output register while the next item is already accepted and
// processed, and the next result is held back until that register has been emptied.
//
// Top level of the block bitmap allocator. Depends on bba_pkg, bba_map_mem,
// bba_scan, bba_ctrl and block_bitmap_allocator_macros.svh.
`include "block_bitmap_allocator_macros.svh"

module block_bitmap_allocator #(
  parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bba_pkg::COUNT_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bba_pkg::FUNC_W-1:0]    func,
  input  logic [bba_pkg::INDEX_W-1:0]   block_index,
  input  logic [bba_pkg::COUNT_W-1:0]   needed_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          free_found,
  output logic [bba_pkg::INDEX_W-1:0]   first_free,
  output logic [bba_pkg::COUNT_W-1:0]   free_total,
  output logic                          enough_free,
  output logic                          index_error
);
  import bba_pkg::*;

  localparam int NWORDS  = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int AW      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int FIRST_W = (AW + WORD_SHIFT > INDEX_W) ? AW + WORD_SHIFT : INDEX_W;
  localparam int TOT_W   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_W-1:0]    mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_W-1:0]    mem_rdata;
  scan_ctrl_t           scan_ctl;
  scan_stat_t           scan_stat;
  logic [CNT_W-1:0]     scan_count;
  logic [FIRST_W-1:0]   scan_first;
  logic [TOT_W-1:0]     scan_total;

  bba_map_mem #(
    .DEPTH (NWORDS),
    .AW    (AW),
    .W     (WORD_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bba_scan #(
    .AW      (AW),
    .CNT_W   (CNT_W),
    .FIRST_W (FIRST_W),
    .TOT_W   (TOT_W)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (scan_ctl),
    .word_addr (mem_raddr),
    .count     (scan_count),
    .rdata     (mem_rdata),
    .stat      (scan_stat),
    .first     (scan_first),
    .total     (scan_total)
  );

  bba_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .AW         (AW),
    .CNT_W      (CNT_W),
    .FIRST_W    (FIRST_W),
    .TOT_W      (TOT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .block_index  (block_index),
    .needed_count (needed_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .free_found   (free_found),
    .first_free   (first_free),
    .free_total   (free_total),
    .enough_free  (enough_free),
    .index_error  (index_error),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .scan_ctl     (scan_ctl),
    .scan_count   (scan_count),
    .scan_stat    (scan_stat),
    .scan_first   (scan_first),
    .scan_total   (scan_total)
  );

  // The sequencer never reads and writes the map in the same cycle.
  `BBA_ASSERT_IMP(a_no_rw_overlap, clk, rst, mem_we, !mem_re)
  // One item at a time: an accepted word closes the input until it is done.
  `BBA_ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)
  // No free block means a zero count, a zero index and not enough room.
  `BBA_ASSERT_IMP(a_none_free, clk, rst, out_valid && !free_found,
                  free_total == '0 && first_free == '0 && !enough_free)
  // A satisfied request always sees a free block.
  `BBA_ASSERT_IMP(a_enough_found, clk, rst, out_valid && enough_free, free_found)

endmodule

@@ test/bba_alloc_checker.sv @@
// Watches the configuration, request and result channels of the block bitmap allocator,
// keeps its own copy of the usage map and checks every result word against it.
// Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_alloc_checker
  import bba_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [FUNC_W-1:0]  func,
  input  logic [INDEX_W-1:0] block_index,
  input  logic [COUNT_W-1:0] needed_count,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               free_found,
  input  logic [INDEX_W-1:0] first_free,
  input  logic [COUNT_W-1:0] free_total,
  input  logic               enough_free,
  input  logic               index_error,
  output int                 mismatch_count,
  output int                 scans_pending
);

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] first;
    logic [COUNT_W-1:0] total;
    logic               enough;
    logic               bad_index;
  } scan_result_t;

  logic [DEF_MAX_BLOCKS-1:0] used_bits;
  logic [COUNT_W-1:0]        block_count;
  scan_result_t              scan_results_due[$];

  // Applies one request to the local map and scans it the way the block does.
  function automatic scan_result_t update_and_scan(logic [FUNC_W-1:0] op,
                                                   logic [INDEX_W-1:0] idx,
                                                   logic [COUNT_W-1:0] need);
    scan_result_t res;
    int           limit;
    int           nfree;
    int           i;
    res   = '0;
    nfree = 0;
    limit = (block_count > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : int'(block_count);
    if (op == FUNC_MARK || op == FUNC_FREE) begin
      if (int'(idx) < limit) used_bits[idx] = (op == FUNC_MARK);
      else res.bad_index = 1'b1;
    end
    // Walking downward leaves the lowest free index in res.first.
    for (i = limit - 1; i >= 0; i--) begin
      if (!used_bits[i]) begin
        res.found = 1'b1;
        res.first = i[INDEX_W-1:0];
        nfree++;
      end
    end
    res.total  = nfree[COUNT_W-1:0];
    res.enough = (need >= 1) && (need <= res.total);
    return res;
  endfunction

  always @(posedge clk) begin
    scan_result_t got;
    scan_result_t want;
    if (rst) begin
      used_bits      = '0;
      block_count    = BLOCK_COUNT_RST;
      mismatch_count = 0;
      scan_results_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{free_found, first_free, free_total, enough_free, index_error};
        if (scan_results_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result word with nothing outstanding: found=%0d first=%0d total=%0d",
                     $realtime, got.found, got.first, got.total);
        end else begin
          want = scan_results_due.pop_front();
          if (got.found !== want.found || got.first !== want.first ||
              got.total !== want.total || got.enough !== want.enough ||
              got.bad_index !== want.bad_index) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: result word mismatch", $realtime);
              $display("  expected found=%0d first=%0d total=%0d enough=%0d index_error=%0d",
                       want.found, want.first, want.total, want.enough, want.bad_index);
              $display("  actual   found=%0d first=%0d total=%0d enough=%0d index_error=%0d",
                       got.found, got.first, got.total, got.enough, got.bad_index);
            end
          end
        end
      end
      if (cfg_we) block_count = cfg_wdata;
      if (in_valid && in_ready)
        scan_results_due.push_back(update_and_scan(func, block_index, needed_count));
    end
    scans_pending = scan_results_due.size();
  end

endmodule

@@ test/tb_block_bitmap_allocator.sv @@
// Stimulus and verdict for the block bitmap allocator: directed corner cases, then
// random phases over several block counts. Depends on bba_pkg, the block and bba_alloc_checker.
`timescale 1ns / 1ps

module tb_block_bitmap_allocator;
  import bba_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int PHASE_WORDS     = 200;
  localparam int PHASES          = 8;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               cfg_we       = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata    = '0;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [FUNC_W-1:0]  func         = FUNC_QUERY;
  logic [INDEX_W-1:0] block_index  = '0;
  logic [COUNT_W-1:0] needed_count = '0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic               free_found;
  logic [INDEX_W-1:0] first_free;
  logic [COUNT_W-1:0] free_total;
  logic               enough_free;
  logic               index_error;
  logic               steady       = 1'b0;
  int                 mismatch_count;
  int                 scans_pending;
  int                 cycle_count  = 0;

  always #6 clk = ~clk;

  block_bitmap_allocator dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .block_index(block_index), .needed_count(needed_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .free_found(free_found), .first_free(first_free), .free_total(free_total),
    .enough_free(enough_free), .index_error(index_error)
  );

  bba_alloc_checker u_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .block_index(block_index), .needed_count(needed_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .free_found(free_found), .first_free(first_free), .free_total(free_total),
    .enough_free(enough_free), .index_error(index_error),
    .mismatch_count(mismatch_count), .scans_pending(scans_pending)
  );

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(negedge clk) out_ready <= steady || ($urandom_range(0, 99) >= 13);

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("block_bitmap_allocator regression: fail");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_request(input logic [FUNC_W-1:0] op, input logic [INDEX_W-1:0] idx,
                              input logic [COUNT_W-1:0] need);
    while (!steady && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    func         <= op;
    block_index  <= idx;
    needed_count <= need;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (scans_pending != 0) @(negedge clk);
  endtask

  // Only called once nothing is outstanding.
  task automatic write_block_count(input logic [COUNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_random_request(input int count);
    int                 span;
    int                 pick;
    logic [FUNC_W-1:0]  op;
    logic [INDEX_W-1:0] idx;
    logic [COUNT_W-1:0] need;
    span = (count > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : count;
    pick = $urandom_range(0, 99);
    op = (pick < 50) ? FUNC_MARK : (pick < 78) ? FUNC_FREE :
         (pick < 95) ? FUNC_QUERY : FUNC_UNKNOWN;
    // Nearly half the requests (45 in 100) crowd the low blocks so the map fills and the lowest free index moves.
    pick = $urandom_range(0, 99);
    if (span == 0 || pick < 10) idx = INDEX_W'($urandom_range(0, DEF_MAX_BLOCKS - 1));
    else if (pick < 55) idx = INDEX_W'($urandom_range(0, ((span < 48) ? span : 48) - 1));
    else idx = INDEX_W'($urandom_range(0, span - 1));
    pick = $urandom_range(0, 99);
    if (pick < 10) need = '0;
    else if (pick < 20) need = COUNT_W'($urandom_range(0, 2047));
    else need = COUNT_W'($urandom_range(1, span + 1));
    send_request(op, idx, need);
  endtask

  initial begin
    int phase_counts[PHASES];
    phase_counts = '{1024, 8, 33, 1, 2047, 0, 64, 1024};
    phase_counts[PHASES-1] = $urandom_range(1, 2047);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Full map at the reset count.
    send_request(FUNC_QUERY, 10'd1023, 11'd0);
    send_request(FUNC_QUERY, 10'd0, 11'd1024);
    send_request(FUNC_QUERY, 10'd512, 11'd2047);
    send_request(FUNC_MARK, 10'd0, 11'd1);
    send_request(FUNC_MARK, 10'd1023, 11'd1023);
    send_request(FUNC_FREE, 10'd0, 11'd1022);
    send_request(FUNC_UNKNOWN, 10'd5, 11'd1);
    send_request(FUNC_MARK, 10'd1023, 11'd1022);
    send_request(FUNC_FREE, 10'd1023, 11'd1024);

    // One block: fill it, then every other index is out of range.
    wait_drained();
    write_block_count(11'd1);
    send_request(FUNC_MARK, 10'd0, 11'd1);
    send_request(FUNC_MARK, 10'd1, 11'd0);
    send_request(FUNC_FREE, 10'd1023, 11'd1);
    send_request(FUNC_QUERY, 10'd0, 11'd0);

    // No blocks at all.
    wait_drained();
    write_block_count(11'd0);
    send_request(FUNC_MARK, 10'd0, 11'd1);
    send_request(FUNC_FREE, 10'd0, 11'd0);
    send_request(FUNC_QUERY, 10'd1023, 11'd1);

    // Oversized count saturates; block 0 is still used from the one-block case.
    wait_drained();
    write_block_count(11'd2047);
    send_request(FUNC_QUERY, 10'd0, 11'd1023);
    send_request(FUNC_MARK, 10'd1023, 11'd1);
    send_request(FUNC_FREE, 10'd0, 11'd1023);

    // Shrunk count leaves block 1023 used but out of view.
    wait_drained();
    write_block_count(11'd3);
    send_request(FUNC_MARK, 10'd2, 11'd2);
    send_request(FUNC_FREE, 10'd1023, 11'd3);
    send_request(FUNC_MARK, 10'd0, 11'd1);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_block_count(phase_counts[p][COUNT_W-1:0]);
      steady <= (p == 2);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (p == 0 && n == PHASE_WORDS / 2) wait_drained();
        send_random_request(phase_counts[p]);
      end
    end

    wait_drained();
    repeat (60) @(negedge clk);
    if (mismatch_count == 0)
      $display("block_bitmap_allocator regression: pass");
    else
      $display("block_bitmap_allocator regression: fail");
    $finish;
  end

endmodule

@@ block_bitmap_allocator.f @@
+incdir+hdl
hdl/bba_pkg.sv
hdl/bba_map_mem.sv
hdl/bba_scan.sv
hdl/bba_ctrl.sv
hdl/block_bitmap_allocator.sv
test/bba_alloc_checker.sv
test/tb_block_bitmap_allocator.sv
